// ===== rtl/ptcomp_pkg.sv =====
`timescale 1ns / 1ps

package ptcomp_pkg;

    // widths of the ports
    localparam int RAW_W    = 24;
    localparam int CAL_W    = 16;
    localparam int IDX_W    = 3;
    localparam int TEMP_W   = 19;
    localparam int PRES_W   = 26;

    // configuration register indexes
    localparam logic [IDX_W-1:0] REG_SENS_AT_REF       = 3'd0;
    localparam logic [IDX_W-1:0] REG_OFFSET_AT_REF     = 3'd1;
    localparam logic [IDX_W-1:0] REG_SENS_TEMP_COEFF   = 3'd2;
    localparam logic [IDX_W-1:0] REG_OFFSET_TEMP_COEFF = 3'd3;
    localparam logic [IDX_W-1:0] REG_REF_TEMPERATURE   = 3'd4;
    localparam logic [IDX_W-1:0] REG_TEMP_SLOPE        = 3'd5;

    // 20.00 C reference point and -15.00 C cold threshold magnitude
    localparam int TEMP_REF   = 2000;
    localparam int TEMP_VCOLD = 1500;

    // second order correction weights
    localparam int K_OFF2_LOW   = 61;
    localparam int K_SENS2_LOW  = 29;
    localparam int K_OFF2_VLOW  = 17;
    localparam int K_SENS2_VLOW = 9;

    // pipeline length from the input register to the last compute stage
    localparam int DEPTH = 9;

endpackage

// ===== rtl/pressure_temp_compensation.sv =====
`timescale 1ns / 1ps

// Second order barometric compensation, fully pipelined.
//
// Input: pulse start with raw_temperature and raw_pressure; the word is taken
// at any rising edge where start is high and busy is low. busy is always low,
// so a new reading pair can be issued every cycle.
// Output: done is high for exactly one cycle with temp_centi (0.01 C),
// pressure_centi (0.01 mbar) and status. Results come back in issue order.
// Each stage holds its result in a register up to the output word;
// throughput is one word per cycle. The pipeline length is set by the chain of
// multiplies: dt, then dt*coefficient, then the squared temperature terms,
// then the raw pressure times sensitivity split in two 20-bit halves.
// status is 1 and both values are 0 when either raw reading is zero.
// Calibration words are written through wr_en / wr_index / wr_data and are
// read live by the datapath, so the user must change them only while nothing
// is in flight; the block does not enforce this. Reset clears the calibration
// words and empties the pipeline. The receiver cannot stall; done is never held off.

module pressure_temp_compensation
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  wr_en,
    input  logic [ptcomp_pkg::IDX_W-1:0]          wr_index,
    input  logic [ptcomp_pkg::CAL_W-1:0]          wr_data,
    input  logic                                  start,
    output logic                                  busy,
    input  logic [ptcomp_pkg::RAW_W-1:0]          raw_temperature,
    input  logic [ptcomp_pkg::RAW_W-1:0]          raw_pressure,
    output logic                                  done,
    output logic signed [ptcomp_pkg::TEMP_W-1:0]  temp_centi,
    output logic signed [ptcomp_pkg::PRES_W-1:0]  pressure_centi,
    output logic                                  status
);

    // calibration words
    logic [15:0] sens_at_ref_reg, offset_at_ref_reg, sens_temp_coeff_reg;
    logic [15:0] offset_temp_coeff_reg, ref_temperature_reg, temp_slope_reg;

    // valid and zero-reading flags travel alongside the data
    logic [ptcomp_pkg::DEPTH:1] valid_reg, valid_next;
    logic [ptcomp_pkg::DEPTH:1] zero_reg, zero_next;
    logic                       accept;

    // stage 1: dt and pressure reading
    logic [24:0] dt1_reg, dt1_next;
    logic [23:0] d1_reg [1:6];

    // stage 2: products with dt
    logic signed [41:0] mt2_reg, mt2_next;
    logic [47:0]        dsq2_reg, dsq2_next;
    logic signed [41:0] moff2_reg, moff2_next;
    logic signed [41:0] msens2_reg, msens2_next;
    logic signed [49:0] dsq_full;

    // stage 3: first order temperature, cold distance, t2 candidates, off1/sens1
    logic [17:0] tc3_reg, tc3_next;
    logic [18:0] tl3_reg, tl3_next;
    logic [16:0] t2c3_reg, t2c3_next;
    logic [16:0] t2w3_reg, t2w3_next;
    logic [40:0] off1_reg [3:5];
    logic [40:0] off1_next;
    logic [39:0] sens1_reg [3:5];
    logic [39:0] sens1_next;
    logic [49:0] t3x;
    logic [50:0] t5x;

    // stage 4: squares and corrected temperature
    logic [34:0] tcsq4_reg, tcsq4_next;
    logic [34:0] tlsq4_reg, tlsq4_next;
    logic        low4_reg, low4_next;
    logic        cold4_reg, cold4_next;
    logic [18:0] temp_reg [4:9];
    logic [18:0] temp4_next;
    logic signed [35:0] tcsq_full;
    logic signed [37:0] tlsq_full;
    logic [16:0] t2_sel;
    logic [19:0] tsum;

    // stage 5: second order offset and sensitivity terms
    logic [40:0] off2_5_reg, off2_5_next;
    logic [39:0] sens2_5_reg, sens2_5_next;
    logic [40:0] off2a_full, off2b_full;
    logic [39:0] sens2a_full, sens2b_full;

    // stage 6: final offset and sensitivity
    logic [40:0] off_reg [6:8];
    logic [40:0] off6_next;
    logic [39:0] sens6_reg, sens6_next;

    // stage 7: partial products of pressure times sensitivity
    logic [43:0]        pplo7_reg, pplo7_next;
    logic signed [44:0] pphi7_reg, pphi7_next;

    // stage 8: full product
    logic [63:0] prod8_reg, prod8_next;

    // stage 9: scaled product minus offset
    logic [43:0] q9_reg, q9_next;

    // output word
    logic        done_reg;
    logic [18:0] temp_out_reg, temp_out_next;
    logic [25:0] pres_out_reg, pres_out_next;
    logic        status_reg;
    logic [28:0] p29;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    // calibration write port, unknown index ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sens_at_ref_reg       <= '0;
            offset_at_ref_reg     <= '0;
            sens_temp_coeff_reg   <= '0;
            offset_temp_coeff_reg <= '0;
            ref_temperature_reg   <= '0;
            temp_slope_reg        <= '0;
        end
        else if (wr_en)
        begin
            case (wr_index)
                ptcomp_pkg::REG_SENS_AT_REF:       sens_at_ref_reg       <= wr_data;
                ptcomp_pkg::REG_OFFSET_AT_REF:     offset_at_ref_reg     <= wr_data;
                ptcomp_pkg::REG_SENS_TEMP_COEFF:   sens_temp_coeff_reg   <= wr_data;
                ptcomp_pkg::REG_OFFSET_TEMP_COEFF: offset_temp_coeff_reg <= wr_data;
                ptcomp_pkg::REG_REF_TEMPERATURE:   ref_temperature_reg   <= wr_data;
                ptcomp_pkg::REG_TEMP_SLOPE:        temp_slope_reg        <= wr_data;
                default:                           ;
            endcase
        end
    end

    always_comb
    begin
        valid_next = {valid_reg[ptcomp_pkg::DEPTH-1:1], accept};
        zero_next  = {zero_reg[ptcomp_pkg::DEPTH-1:1],
                      (raw_temperature == '0) || (raw_pressure == '0)};

        // stage 1: dt = D2 - C5*256
        dt1_next = {1'b0, raw_temperature} - {1'b0, ref_temperature_reg, 8'b0};

        // stage 2: one multiplier per product
        mt2_next    = $signed(dt1_reg) * $signed({1'b0, temp_slope_reg});
        dsq_full    = $signed(dt1_reg) * $signed(dt1_reg);
        dsq2_next   = dsq_full[47:0];
        moff2_next  = $signed(dt1_reg) * $signed({1'b0, offset_temp_coeff_reg});
        msens2_next = $signed(dt1_reg) * $signed({1'b0, sens_temp_coeff_reg});

        // stage 3: tc = (dt*C6) >>> 23, the shifted value fits 18 bits
        tc3_next  = mt2_reg[40:23];
        tl3_next  = {tc3_next[17], tc3_next}
                    + 19'(ptcomp_pkg::TEMP_REF + ptcomp_pkg::TEMP_VCOLD);
        // 3*dt^2 >> 33 for the low branch, 5*dt^2 >> 38 otherwise
        t3x       = {2'b0, dsq2_reg} + {1'b0, dsq2_reg, 1'b0};
        t5x       = {3'b0, dsq2_reg} + {1'b0, dsq2_reg, 2'b0};
        t2c3_next = t3x[49:33];
        t2w3_next = {4'b0, t5x[50:38]};
        off1_next  = {8'b0, offset_at_ref_reg, 17'b0}
                     + {{5{moff2_reg[41]}}, moff2_reg[41:6]};
        sens1_next = {8'b0, sens_at_ref_reg, 16'b0}
                     + {{5{msens2_reg[41]}}, msens2_reg[41:7]};

        // stage 4: below 20.00 C when tc < 0, below -15.00 C when tl < 0
        tcsq_full  = $signed(tc3_reg) * $signed(tc3_reg);
        tlsq_full  = $signed(tl3_reg) * $signed(tl3_reg);
        tcsq4_next = tcsq_full[34:0];
        tlsq4_next = tlsq_full[34:0];
        low4_next  = tc3_reg[17];
        cold4_next = tl3_reg[18] && tc3_reg[17];
        t2_sel     = tc3_reg[17] ? t2c3_reg : t2w3_reg;
        // stays inside 19 bits for every input, no clamp needed
        tsum       = {{2{tc3_reg[17]}}, tc3_reg} + 20'(ptcomp_pkg::TEMP_REF)
                     - {3'b0, t2_sel};
        temp4_next = tsum[18:0];

        // stage 5: constant weights are shift-add
        off2a_full  = 41'(tcsq4_reg) * 41'(ptcomp_pkg::K_OFF2_LOW);
        off2b_full  = 41'(tlsq4_reg) * 41'(ptcomp_pkg::K_OFF2_VLOW);
        sens2a_full = 40'(tcsq4_reg) * 40'(ptcomp_pkg::K_SENS2_LOW);
        sens2b_full = 40'(tlsq4_reg) * 40'(ptcomp_pkg::K_SENS2_VLOW);
        off2_5_next  = (low4_reg  ? {4'b0, off2a_full[40:4]} : '0)
                       + (cold4_reg ? off2b_full : '0);
        sens2_5_next = (low4_reg  ? {4'b0, sens2a_full[39:4]} : '0)
                       + (cold4_reg ? sens2b_full : '0);

        // stage 6
        off6_next  = off1_reg[5] - off2_5_reg;
        sens6_next = sens1_reg[5] - sens2_5_reg;

        // stage 7: D1 * SENS as signed upper half and unsigned lower half
        pplo7_next = 44'(d1_reg[6]) * 44'(sens6_reg[19:0]);
        pphi7_next = $signed({1'b0, d1_reg[6]}) * $signed(sens6_reg[39:20]);

        // stage 8
        prod8_next = {pphi7_reg[43:0], 20'b0} + {20'b0, pplo7_reg};

        // stage 9: (prod >>> 21) - off
        q9_next = {prod8_reg[63], prod8_reg[63:21]} - {{3{off_reg[8][40]}}, off_reg[8]};

        // output: >>> 15 then saturate to 26 bits
        p29 = q9_reg[43:15];
        if (p29[28:25] == {4{p29[25]}})
        begin
            pres_out_next = p29[25:0];
        end
        else if (p29[28])
        begin
            pres_out_next = {1'b1, 25'b0};
        end
        else
        begin
            pres_out_next = {1'b0, {25{1'b1}}};
        end
        temp_out_next = temp_reg[9];
        if (zero_reg[ptcomp_pkg::DEPTH])
        begin
            pres_out_next = '0;
            temp_out_next = '0;
        end
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            done_reg  <= valid_reg[ptcomp_pkg::DEPTH];
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        zero_reg     <= zero_next;
        dt1_reg      <= dt1_next;
        d1_reg[1]    <= raw_pressure;
        for (int i = 2; i <= 6; i++)
        begin
            d1_reg[i] <= d1_reg[i-1];
        end
        mt2_reg      <= mt2_next;
        dsq2_reg     <= dsq2_next;
        moff2_reg    <= moff2_next;
        msens2_reg   <= msens2_next;
        tc3_reg      <= tc3_next;
        tl3_reg      <= tl3_next;
        t2c3_reg     <= t2c3_next;
        t2w3_reg     <= t2w3_next;
        off1_reg[3]  <= off1_next;
        off1_reg[4]  <= off1_reg[3];
        off1_reg[5]  <= off1_reg[4];
        sens1_reg[3] <= sens1_next;
        sens1_reg[4] <= sens1_reg[3];
        sens1_reg[5] <= sens1_reg[4];
        tcsq4_reg    <= tcsq4_next;
        tlsq4_reg    <= tlsq4_next;
        low4_reg     <= low4_next;
        cold4_reg    <= cold4_next;
        temp_reg[4]  <= temp4_next;
        for (int i = 5; i <= 9; i++)
        begin
            temp_reg[i] <= temp_reg[i-1];
        end
        off2_5_reg   <= off2_5_next;
        sens2_5_reg  <= sens2_5_next;
        off_reg[6]   <= off6_next;
        off_reg[7]   <= off_reg[6];
        off_reg[8]   <= off_reg[7];
        sens6_reg    <= sens6_next;
        pplo7_reg    <= pplo7_next;
        pphi7_reg    <= pphi7_next;
        prod8_reg    <= prod8_next;
        q9_reg       <= q9_next;
        temp_out_reg <= temp_out_next;
        pres_out_reg <= pres_out_next;
        status_reg   <= zero_reg[ptcomp_pkg::DEPTH];
    end

    assign done           = done_reg;
    assign temp_centi     = $signed(temp_out_reg);
    assign pressure_centi = $signed(pres_out_reg);
    assign status         = status_reg;

    // every accepted word comes back as a done pulse
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##10 done)
        else $error("result word missing");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |-> ##10 !done)
        else $error("result word without a request");

    // a zero raw reading flags the word as invalid
    a_zero_flag: assert property (@(posedge clk) disable iff (!rst_n)
        accept && ((raw_temperature == '0) || (raw_pressure == '0)) |-> ##10 status)
        else $error("zero reading not flagged");

    a_zero_values: assert property (@(posedge clk) disable iff (!rst_n)
        done && status |-> (temp_centi == '0) && (pressure_centi == '0))
        else $error("invalid word carries nonzero values");

endmodule
